// ===== hdl/pfc_pkg.sv =====
// Shared types and constants for the Playfair digraph cipher unit.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int SQ_CELLS    = 25;
  localparam int NUM_LETTERS = 26;

  // Letter indexes, A = 0
  localparam logic [4:0] LTR_I = 5'd8;
  localparam logic [4:0] LTR_J = 5'd9;
  localparam logic [4:0] LTR_X = 5'd23;

  typedef enum logic [1:0] {OP_KEY, OP_KEY_END, OP_TEXT, OP_TEXT_END} pfc_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } pfc_in_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       pair_end;
  } pfc_out_t;

  // Request to the square builder: place one letter in the next free cell
  typedef struct packed {
    logic       en;
    logic [4:0] letter;
  } place_req_t;

endpackage

// ===== hdl/pfc_key_store.sv =====
// Key square and letter position memories with the shared letter placement unit.
`timescale 1ns / 1ps

module pfc_key_store (
  input  logic                clk,
  input  logic                rst,
  input  pfc_pkg::place_req_t place,
  input  logic [4:0]          sq_raddr,
  output logic [4:0]          sq_rdata,
  input  logic [4:0]          pl_raddr,
  output logic [4:0]          pl_rdata
);
  import pfc_pkg::*;

  logic [4:0]             key_square [SQ_CELLS];
  logic [4:0]             letter_place [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] letter_used;
  logic [4:0]             fill_count;
  logic                   take;

  // Place only letters not yet in the square, and only while cells remain
  assign take = place.en && !letter_used[place.letter] && (fill_count < 5'(SQ_CELLS));

  always_ff @(posedge clk) begin
    if (take) begin
      key_square[fill_count]     <= place.letter;
      letter_place[place.letter] <= fill_count;
    end
    sq_rdata <= key_square[sq_raddr];
    pl_rdata <= letter_place[pl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (take) begin
      letter_used[place.letter] <= 1'b1;
      fill_count                <= fill_count + 5'd1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 5'(SQ_CELLS))
    else $error("fill count past square size");

  a_take_count: assert property (@(posedge clk) disable iff (rst)
    take |=> (fill_count == $past(fill_count) + 5'd1))
    else $error("placement did not advance fill count");

  a_take_mark: assert property (@(posedge clk) disable iff (rst)
    take |=> letter_used[$past(place.letter)])
    else $error("placed letter not marked used");

endmodule

// ===== hdl/pfc_digraph_rule.sv =====
// Row, column and rectangle rule: maps two square positions to the two result cells.
`timescale 1ns / 1ps

module pfc_digraph_rule (
  input  logic [4:0] pa,
  input  logic [4:0] pb,
  input  logic       dir,
  output logic [4:0] cx,
  output logic [4:0] cy
);

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // one step along a row or column, wrapping mod 5; dir set steps back
  function automatic logic [2:0] step(input logic [2:0] v, input logic d);
    logic [2:0] n;
    if (d) n = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else   n = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return n;
  endfunction

  logic [2:0] ra, rb, ca, cb;
  logic [4:0] base_a, base_b;

  always_comb begin
    ra     = row_of(pa);
    rb     = row_of(pb);
    base_a = cell_at(ra, 3'd0);
    base_b = cell_at(rb, 3'd0);
    ca     = 3'(pa - base_a);
    cb     = 3'(pb - base_b);
    if (ra == rb) begin
      cx = cell_at(ra, step(ca, dir));
      cy = cell_at(rb, step(cb, dir));
    end else if (ca == cb) begin
      cx = cell_at(step(ra, dir), ca);
      cy = cell_at(step(rb, dir), cb);
    end else begin
      cx = cell_at(ra, cb);
      cy = cell_at(rb, ca);
    end
  end

endmodule

// ===== hdl/playfair_digraph_cipher_unit.sv =====
// Top level: Playfair cipher with key schedule, sequencer and output buffer.
//
//  channel  | signals                        | beat
//  ---------+--------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data    | opcode + char_code
//  out      | out_valid, out_ready, out_data | letter + pair_end
//  cfg      | cfg_wr_en, cfg_wr_data         | direction bit, no handshake
//
// Key bytes, text letters that open a pair and ignored items are taken in S_IDLE.
// End of key: the placement unit walks A..Z one letter a cycle.
// Text letter or end of text that closes a pair: S_RD_A, S_RD_B, S_CALC, S_SQ_Y,
// S_SQ_DONE, S_LOAD; one read port per memory (two position, two square reads).
// The pair is loaded only once both earlier letters have left the output buffer.
// Synchronous reset clears control state; memory contents are never used unwritten.
`timescale 1ns / 1ps

module playfair_digraph_cipher_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pfc_pkg::pfc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pfc_pkg::pfc_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_RD_A, S_RD_B, S_CALC, S_SQ_Y, S_SQ_DONE, S_LOAD
  } state_t;

  state_t     state;
  logic       direction;
  logic       key_ready;
  logic       held_valid;
  logic [4:0] held_letter;
  logic [4:0] b_letter;
  logic [4:0] walk;
  logic [4:0] pa_reg;
  logic [4:0] cy_reg;
  logic [4:0] x_reg;
  logic [4:0] y_reg;
  logic [4:0] slot0;
  logic [4:0] slot1;
  logic [1:0] ob_count;

  logic       in_accept;
  logic       fold_ok;
  logic [4:0] fold_raw;
  logic [4:0] fold_idx;
  place_req_t place;
  logic [4:0] sq_raddr, sq_rdata;
  logic [4:0] pl_raddr, pl_rdata;
  logic [4:0] cx, cy;
  logic [4:0] out_sel;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // A..Z and a..z share low bits 1..26 in the 0x40 and 0x60 groups
  always_comb begin
    fold_raw = in_data.char_code[4:0] - 5'd1;
    fold_ok  = ((in_data.char_code[7:5] == 3'b010) || (in_data.char_code[7:5] == 3'b011))
               && (in_data.char_code[4:0] != 5'd0) && (in_data.char_code[4:0] <= 5'd26);
    fold_idx = (fold_raw == LTR_J) ? LTR_I : fold_raw;
  end

  always_comb begin
    if (state == S_FILL) begin
      place.en     = (walk != LTR_J);
      place.letter = walk;
    end else begin
      place.en     = in_accept && (in_data.opcode == OP_KEY) && !key_ready && fold_ok;
      place.letter = fold_idx;
    end
  end

  assign pl_raddr = (state == S_RD_A) ? held_letter : b_letter;
  assign sq_raddr = (state == S_CALC) ? cx : cy_reg;

  pfc_key_store u_store (
    .clk      (clk),
    .rst      (rst),
    .place    (place),
    .sq_raddr (sq_raddr),
    .sq_rdata (sq_rdata),
    .pl_raddr (pl_raddr),
    .pl_rdata (pl_rdata)
  );

  // in S_CALC the position read returns the second letter's cell
  pfc_digraph_rule u_rule (
    .pa  (pa_reg),
    .pb  (pl_rdata),
    .dir (direction),
    .cx  (cx),
    .cy  (cy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      direction  <= 1'b0;
      key_ready  <= 1'b0;
      held_valid <= 1'b0;
      ob_count   <= 2'd0;
      walk       <= 5'd0;
    end else begin
      if (cfg_wr_en) direction <= cfg_wr_data;
      if (out_valid && out_ready) ob_count <= ob_count - 2'd1;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.opcode)
              OP_KEY: begin
                // placement happens in the store this cycle
              end
              OP_KEY_END: begin
                if (!key_ready) begin
                  walk  <= 5'd0;
                  state <= S_FILL;
                end
              end
              OP_TEXT: begin
                if (key_ready && fold_ok) begin
                  if (!held_valid) begin
                    held_letter <= fold_idx;
                    held_valid  <= 1'b1;
                  end else begin
                    b_letter   <= fold_idx;
                    held_valid <= 1'b0;
                    state      <= S_RD_A;
                  end
                end
              end
              OP_TEXT_END: begin
                if (key_ready && held_valid) begin
                  b_letter   <= LTR_X;
                  held_valid <= 1'b0;
                  state      <= S_RD_A;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          walk <= walk + 5'd1;
          if (walk == 5'(NUM_LETTERS - 1)) begin
            key_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          pa_reg <= pl_rdata;
          state  <= S_CALC;
        end
        S_CALC: begin
          cy_reg <= cy;
          state  <= S_SQ_Y;
        end
        S_SQ_Y: begin
          x_reg <= sq_rdata;
          state <= S_SQ_DONE;
        end
        S_SQ_DONE: begin
          y_reg <= sq_rdata;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (ob_count == 2'd0) begin
            slot0    <= x_reg;
            slot1    <= y_reg;
            ob_count <= 2'd2;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = (ob_count != 2'd0);
  assign out_sel           = (ob_count == 2'd2) ? slot0 : slot1;
  assign out_data.letter   = 7'd65 + {2'b00, out_sel};
  assign out_data.pair_end = ob_count[0];

  a_load_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && ob_count == 2'd0) |=> (ob_count == 2'd2 && state == S_IDLE))
    else $error("pair not loaded into empty output buffer");

  a_fill_before_key: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !key_ready)
    else $error("fill walk running with key already complete");

  a_pair_needs_key: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_A) |-> (key_ready && !held_valid))
    else $error("pair lookup started without a finished key");

endmodule
